// ===== hw/rtl/hrs_pkg.sv =====
// Shared types, constants and helpers for the Hessian ridge score pipeline.
// No dependencies; every other file in hw/rtl imports this package.
package hrs_pkg;

  // Fixed output field widths
  localparam int MAJ_W   = 26;
  localparam int SCORE_W = 25;
  localparam int DIR_W   = 22;

  // Angle unit geometry
  localparam int CORDIC_N  = 32;
  localparam int NORM_N    = 6;
  localparam int Z_W       = 36;
  localparam int NORM_EXP  = 60;
  localparam logic signed [63:0] HALF_PI_Q32 = 64'sd6746518852;

  // atan(2^-i) in units of 2^-32 rad, rounded to nearest
  localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  // Side data that rides along the angle unit
  typedef struct packed {
    logic signed [MAJ_W-1:0] eig_major;
    logic signed [MAJ_W-1:0] eig_minor;
    logic [SCORE_W-1:0]      ridge_score;
    logic signed [DIR_W-1:0] direction;
    logic                    direction_undefined;
    logic                    use_cordic;
    logic                    negate;
  } eig_side_t;

  // One result word
  typedef struct packed {
    logic signed [MAJ_W-1:0] eig_major;
    logic signed [MAJ_W-1:0] eig_minor;
    logic [SCORE_W-1:0]      ridge_score;
    logic signed [DIR_W-1:0] direction;
    logic                    direction_undefined;
  } out_word_t;

  // Clamp a signed value into [lo, hi]
  function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    logic signed [63:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

  // pi/2 rounded to f fraction bits, half up
  function automatic logic signed [63:0] half_pi_q(input int f);
    logic signed [63:0] r;
    r = (HALF_PI_Q32 + (64'sd1 <<< (31 - f))) >>> (32 - f);
    return r;
  endfunction

endpackage

// ===== hw/rtl/hrs_front.sv =====
// Front end: differences, absolute values, the two squares and the discriminant.
// Depends on hrs_pkg; three register stages under a shared advance enable.
module hrs_front import hrs_pkg::*; #(
  parameter int W = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [W-1:0]  dxx,
  input  logic signed [W-1:0]  dyy,
  input  logic signed [W-1:0]  dxy,
  output logic                 out_valid,
  output logic [2*W+1:0]       out_d,
  output logic signed [W:0]    out_s,
  output logic signed [W-1:0]  out_xx,
  output logic signed [W-1:0]  out_xy
);

  logic signed [W:0] diff;
  logic [W:0]        diff_abs;
  logic [W-1:0]      xy_abs;

  logic              v1, v2, v3;
  logic [W:0]        a1, b1;
  logic signed [W:0] s1, s2;
  logic signed [W-1:0] xx1, xy1, xx2, xy2;
  logic [2*W+1:0]    sqa, sqb, prod_a, prod_b;

  // Form the difference, its magnitude and |dxy|
  assign diff     = (W+1)'(dxx) - (W+1)'(dyy);
  assign diff_abs = diff[W] ? (~diff + 1'b1) : diff;
  assign xy_abs   = dxy[W-1] ? (~dxy + 1'b1) : dxy;

  assign prod_a = {{(W+1){1'b0}}, a1} * {{(W+1){1'b0}}, a1};
  assign prod_b = {{(W+1){1'b0}}, b1} * {{(W+1){1'b0}}, b1};

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a1     <= diff_abs;
      b1     <= {xy_abs, 1'b0};
      s1     <= (W+1)'(dxx) + (W+1)'(dyy);
      xx1    <= dxx;
      xy1    <= dxy;
      sqa    <= prod_a;
      sqb    <= prod_b;
      s2     <= s1;
      xx2    <= xx1;
      xy2    <= xy1;
      out_d  <= sqa + sqb;
      out_s  <= s2;
      out_xx <= xx2;
      out_xy <= xy2;
    end
  end

  assign out_valid = v3;

endmodule

// ===== hw/rtl/hrs_isqrt.sv =====
// Pipelined floor square root, one root bit resolved per register stage.
// Depends on hrs_pkg; side data of width SBW travels with each word.
module hrs_isqrt import hrs_pkg::*; #(
  parameter int DW  = 50,
  parameter int RW  = 25,
  parameter int SBW = 73
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_d,
  input  logic [SBW-1:0] in_sb,
  output logic           out_valid,
  output logic [RW-1:0]  out_root,
  output logic [SBW-1:0] out_sb
);

  logic [DW:0]    rem  [RW];
  logic [RW-1:0]  root [RW];
  logic [SBW-1:0] sb   [RW];
  logic           vld  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [DW:0]    p_rem;
    logic [RW-1:0]  p_root;
    logic [SBW-1:0] p_sb;
    logic           p_vld;
    logic [DW:0]    trial;

    if (k == 0) begin : g_src
      assign p_rem  = (DW+1)'(in_d);
      assign p_root = '0;
      assign p_sb   = in_sb;
      assign p_vld  = in_valid;
    end else begin : g_src
      assign p_rem  = rem[k-1];
      assign p_root = root[k-1];
      assign p_sb   = sb[k-1];
      assign p_vld  = vld[k-1];
    end

    // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
    assign trial = ((DW+1)'(p_root) << (B + 1)) | ((DW+1)'(1) << (2 * B));

    // Hold valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    // Keep the bit when the trial square still fits
    always_ff @(posedge clk) begin
      if (en) begin
        sb[k] <= p_sb;
        if (p_rem >= trial) begin
          rem[k]  <= p_rem - trial;
          root[k] <= p_root | (RW'(1) << B);
        end else begin
          rem[k]  <= p_rem;
          root[k] <= p_root;
        end
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_sb    = sb[RW-1];

endmodule

// ===== hw/rtl/hrs_eigen.sv =====
// Eigenvalues, ridge score, angle numerator and the special angle cases.
// Depends on hrs_pkg; one register stage under the shared advance enable.
module hrs_eigen import hrs_pkg::*; #(
  parameter int W = 24,
  parameter int F = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [W:0]          root,
  input  logic signed [W:0]   s,
  input  logic signed [W-1:0] xx,
  input  logic signed [W-1:0] xy,
  output logic                out_valid,
  output eig_side_t           out_side,
  output logic [W+1:0]        out_nx,
  output logic [W+1:0]        out_ny
);

  localparam int EW = W + 4;

  logic signed [EW-1:0] s_e, r_e, l1, l2, al1, score, num, num_abs;
  logic signed [63:0]   maj_w, min_w, score_w, hp, dir_sp, dir_w;
  logic [W-1:0]         xy_abs;
  eig_side_t            side;

  assign s_e   = EW'(s);
  assign r_e   = $signed(EW'(root));
  assign l1    = (s_e + r_e) >>> 1;
  assign l2    = (s_e - r_e) >>> 1;
  assign al1   = l1[EW-1] ? -l1 : l1;
  assign score = -l2 - al1;
  assign num   = l1 - EW'(xx);
  assign num_abs = num[EW-1] ? -num : num;
  assign xy_abs  = xy[W-1] ? (~xy + 1'b1) : xy;

  assign hp = half_pi_q(F);

  // Clamp the results into their port ranges
  always_comb begin
    maj_w   = sat64(64'(l1), -(64'sd1 <<< 25), (64'sd1 <<< 25) - 64'sd1);
    min_w   = sat64(64'(l2), -(64'sd1 <<< 25), (64'sd1 <<< 25) - 64'sd1);
    score_w = sat64(64'(score), 64'sd0, (64'sd1 <<< 25) - 64'sd1);
    dir_sp  = 64'sd0;
    if (xy == '0) begin
      if (num > 0) dir_sp = hp;
      else if (num < 0) dir_sp = -hp;
    end
    dir_w = sat64(dir_sp, -(64'sd1 <<< 21), (64'sd1 <<< 21) - 64'sd1);
    side.eig_major           = maj_w[MAJ_W-1:0];
    side.eig_minor           = min_w[MAJ_W-1:0];
    side.ridge_score         = score_w[SCORE_W-1:0];
    side.direction           = dir_w[DIR_W-1:0];
    side.direction_undefined = (xy == '0) && (num == '0);
    side.use_cordic          = (xy != '0) && (num != '0);
    side.negate              = num[EW-1] != xy[W-1];
  end

  // Hold valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Register results and the angle operands
  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side;
      out_nx   <= (W+2)'(xy_abs);
      out_ny   <= num_abs[W+1:0];
    end
  end

endmodule

// ===== hw/rtl/hrs_cordic.sv =====
// Angle unit: normalizing shifter stages, CORDIC vectoring stages, rounding.
// Depends on hrs_pkg; side data rides along and is merged in the last stage.
module hrs_cordic import hrs_pkg::*; #(
  parameter int NW = 26,
  parameter int F  = 20
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_nx,
  input  logic [NW-1:0] in_ny,
  input  eig_side_t     in_side,
  output logic          out_valid,
  output out_word_t     out_word
);

  logic [63:0]          nxs [NORM_N];
  logic [63:0]          nys [NORM_N];
  eig_side_t            nsd [NORM_N];
  logic                 nvl [NORM_N];

  logic signed [63:0]   cx  [CORDIC_N];
  logic signed [63:0]   cy  [CORDIC_N];
  logic signed [Z_W-1:0] cz [CORDIC_N];
  eig_side_t            csd [CORDIC_N];
  logic                 cvl [CORDIC_N];

  // Normalize so the larger operand lands in [2^59, 2^60)
  for (genvar j = 0; j < NORM_N; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic [63:0] p_nx, p_ny, m;
    eig_side_t   p_sd;
    logic        p_vl;

    if (j == 0) begin : g_src
      assign p_nx = 64'(in_nx);
      assign p_ny = 64'(in_ny);
      assign p_sd = in_side;
      assign p_vl = in_valid;
    end else begin : g_src
      assign p_nx = nxs[j-1];
      assign p_ny = nys[j-1];
      assign p_sd = nsd[j-1];
      assign p_vl = nvl[j-1];
    end

    assign m = p_nx | p_ny;

    always_ff @(posedge clk) begin
      if (rst) begin
        nvl[j] <= 1'b0;
      end else if (en) begin
        nvl[j] <= p_vl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nsd[j] <= p_sd;
        if (m < (64'd1 << (NORM_EXP - SH))) begin
          nxs[j] <= p_nx << SH;
          nys[j] <= p_ny << SH;
        end else begin
          nxs[j] <= p_nx;
          nys[j] <= p_ny;
        end
      end
    end
  end

  // Rotate toward the x axis, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
    logic signed [63:0]    p_x, p_y, dx, dy;
    logic signed [Z_W-1:0] p_z, at;
    eig_side_t             p_sd;
    logic                  p_vl;

    if (i == 0) begin : g_src
      assign p_x  = $signed(nxs[NORM_N-1]);
      assign p_y  = $signed(nys[NORM_N-1]);
      assign p_z  = '0;
      assign p_sd = nsd[NORM_N-1];
      assign p_vl = nvl[NORM_N-1];
    end else begin : g_src
      assign p_x  = cx[i-1];
      assign p_y  = cy[i-1];
      assign p_z  = cz[i-1];
      assign p_sd = csd[i-1];
      assign p_vl = cvl[i-1];
    end

    assign dx = p_y >>> i;
    assign dy = p_x >>> i;
    assign at = $signed(Z_W'(ATAN_TAB[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        cvl[i] <= 1'b0;
      end else if (en) begin
        cvl[i] <= p_vl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        csd[i] <= p_sd;
        if (!p_y[63]) begin
          cx[i] <= p_x + dx;
          cy[i] <= p_y - dy;
          cz[i] <= p_z + at;
        end else begin
          cx[i] <= p_x - dx;
          cy[i] <= p_y + dy;
          cz[i] <= p_z - at;
        end
      end
    end
  end

  // Round the angle, clamp, apply sign and pick the special case
  logic signed [63:0] q, qs, qd, qf, hp;
  eig_side_t          fsd;
  out_word_t          word_next;

  assign fsd = csd[CORDIC_N-1];
  assign hp  = half_pi_q(F);

  always_comb begin
    q  = (64'(cz[CORDIC_N-1]) + (64'sd1 <<< (31 - F))) >>> (32 - F);
    qs = sat64(q, 64'sd0, hp);
    qd = fsd.negate ? -qs : qs;
    qf = sat64(qd, -(64'sd1 <<< 21), (64'sd1 <<< 21) - 64'sd1);
    word_next.eig_major           = fsd.eig_major;
    word_next.eig_minor           = fsd.eig_minor;
    word_next.ridge_score         = fsd.ridge_score;
    word_next.direction           = fsd.use_cordic ? qf[DIR_W-1:0] : fsd.direction;
    word_next.direction_undefined = fsd.direction_undefined;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cvl[CORDIC_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

// ===== hw/rtl/hrs_out_buf.sv =====
// Two-entry output buffer that decouples the pipeline from the result channel.
// Depends on hrs_pkg; drives the pipeline advance enable from its fill count.
module hrs_out_buf import hrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_word,
  output logic      en,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  out_word_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign en        = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_word  = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    if (pop && !push) count_next = count - 2'd1;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("output buffer count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !en |-> !push) else $error("word pushed into a full buffer");
  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && !push) |=> $stable(count))
    else $error("buffer count moved without a push or pop");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr)) else $error("buffer pointers disagree");
`endif

endmodule

// ===== hw/rtl/hessian_ridge_score_top.sv =====
// Top level of the Hessian ridge score pipeline: front, square root, eigen,
// angle unit and output buffer. Depends on hrs_pkg and the hrs_* modules.
//
//   channel | handshake          | words
//   input   | in_valid/in_ready  | deriv_xx, deriv_yy, deriv_xy
//   output  | out_valid/out_ready| eig_major, eig_minor, ridge_score,
//           |                    | direction, direction_undefined
//
// One word enters per cycle while in_ready is high; words pass the front
// registers, the root bit stages, the eigen register, the normalizing stages,
// the 32 rotations and the rounding register, then the output buffer.
// Synchronous reset clears the valid bits and the output buffer only.
// The whole pipeline advances together unless both output buffer entries are
// full; a word waiting at the output does not stop input while one entry is free.
module hessian_ridge_score_top import hrs_pkg::*; #(
  parameter int IN_WIDTH  = 24,
  parameter int FRAC_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [IN_WIDTH-1:0]  deriv_xx,
  input  logic signed [IN_WIDTH-1:0]  deriv_yy,
  input  logic signed [IN_WIDTH-1:0]  deriv_xy,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [MAJ_W-1:0]     eig_major,
  output logic signed [MAJ_W-1:0]     eig_minor,
  output logic [SCORE_W-1:0]          ridge_score,
  output logic signed [DIR_W-1:0]     direction,
  output logic                        direction_undefined
);

  localparam int W   = IN_WIDTH;
  localparam int DW  = 2 * W + 2;
  localparam int RW  = W + 1;
  localparam int SBW = 3 * W + 1;

  logic                en;
  logic                f_valid, q_valid, e_valid, c_valid;
  logic [DW-1:0]       f_d;
  logic signed [W:0]   f_s;
  logic signed [W-1:0] f_xx, f_xy;
  logic [SBW-1:0]      q_sb;
  logic [RW-1:0]       q_root;
  eig_side_t           e_side;
  logic [W+1:0]        e_nx, e_ny;
  out_word_t           c_word, o_word;

  assign in_ready = en;

  hrs_front #(.W(W)) u_front (
    .clk, .rst, .en,
    .in_valid  (in_valid),
    .dxx       (deriv_xx),
    .dyy       (deriv_yy),
    .dxy       (deriv_xy),
    .out_valid (f_valid),
    .out_d     (f_d),
    .out_s     (f_s),
    .out_xx    (f_xx),
    .out_xy    (f_xy)
  );

  hrs_isqrt #(.DW(DW), .RW(RW), .SBW(SBW)) u_isqrt (
    .clk, .rst, .en,
    .in_valid  (f_valid),
    .in_d      (f_d),
    .in_sb     ({f_s, f_xx, f_xy}),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_sb    (q_sb)
  );

  hrs_eigen #(.W(W), .F(FRAC_BITS)) u_eigen (
    .clk, .rst, .en,
    .in_valid  (q_valid),
    .root      (q_root),
    .s         ($signed(q_sb[SBW-1:2*W])),
    .xx        ($signed(q_sb[2*W-1:W])),
    .xy        ($signed(q_sb[W-1:0])),
    .out_valid (e_valid),
    .out_side  (e_side),
    .out_nx    (e_nx),
    .out_ny    (e_ny)
  );

  hrs_cordic #(.NW(W + 2), .F(FRAC_BITS)) u_cordic (
    .clk, .rst, .en,
    .in_valid  (e_valid),
    .in_nx     (e_nx),
    .in_ny     (e_ny),
    .in_side   (e_side),
    .out_valid (c_valid),
    .out_word  (c_word)
  );

  hrs_out_buf u_out_buf (
    .clk, .rst,
    .push      (en && c_valid),
    .push_word (c_word),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (o_word)
  );

  assign eig_major           = o_word.eig_major;
  assign eig_minor           = o_word.eig_minor;
  assign ridge_score         = o_word.ridge_score;
  assign direction           = o_word.direction;
  assign direction_undefined = o_word.direction_undefined;

`ifndef SYNTHESIS
  a_stall_has_word: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid) else $error("input stalled with no word at the output");
  a_undef_zero_dir: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction_undefined) |-> (direction == '0))
    else $error("undefined direction carries a nonzero angle");
  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (eig_minor <= eig_major)) else $error("eigenvalues out of order");
`endif

endmodule

// ===== test/tb_hessian_ridge_score_top.sv =====
// Testbench for hessian_ridge_score_top: drives Hessian triples, predicts
// eigenvalues, ridge score and direction angle, and checks every output word.
// Depends on hrs_pkg and the RTL of the pipeline.
`timescale 1ns / 100ps

module tb_hessian_ridge_score_top import hrs_pkg::*;;

  localparam int IW = 24;
  localparam int FB = 20;
  localparam int LATENCY = 3 + (IW + 1) + 1 + 6 + 32 + 1 + 1;
  localparam int STALL_LIMIT = 4000;
  localparam int N_RANDOM = 1000;

  typedef struct packed {
    logic signed [IW-1:0] dxx;
    logic signed [IW-1:0] dyy;
    logic signed [IW-1:0] dxy;
  } hess_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IW-1:0] deriv_xx = '0, deriv_yy = '0, deriv_xy = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [MAJ_W-1:0] eig_major, eig_minor;
  logic [SCORE_W-1:0] ridge_score;
  logic signed [DIR_W-1:0] direction;
  logic direction_undefined;

  hess_t pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_sender = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int stall_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  always #6 clk = ~clk;

  hessian_ridge_score_top #(.IN_WIDTH(IW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .deriv_xx(deriv_xx), .deriv_yy(deriv_yy), .deriv_xy(deriv_xy),
    .out_valid(out_valid), .out_ready(out_ready),
    .eig_major(eig_major), .eig_minor(eig_minor), .ridge_score(ridge_score),
    .direction(direction), .direction_undefined(direction_undefined)
  );

  // Append one triple to the pending queue
  function automatic void queue_word(longint a, longint b, longint c);
    hess_t h;
    h.dxx = IW'(a);
    h.dyy = IW'(b);
    h.dxy = IW'(c);
    pending_words.insert(pending_words.size(), h);
  endfunction

  // floor division by 2^s on signed values
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // atan(ny/nx) in Q.FB, both positive, result in [0, pi/2]
  function automatic longint vector_angle(logic [63:0] nx, logic [63:0] ny);
    logic [63:0] m;
    longint x, y, z, dx, dy, q, hp;
    m = nx > ny ? nx : ny;
    z = 0;
    while (m < (64'd1 << 59)) begin
      m = m << 1; nx = nx << 1; ny = ny << 1;
    end
    x = nx;
    y = ny;
    for (int i = 0; i < 32; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
      end
    end
    q = floor_shr(z + (64'sd1 <<< (31 - FB)), 32 - FB);
    hp = floor_shr(HALF_PI_Q32 + (64'sd1 <<< (31 - FB)), 32 - FB);
    return clamp(q, 0, hp);
  endfunction

  // Eigen decomposition, ridge score and eigenvector angle of one pixel
  function automatic out_word_t ridge_of(hess_t h);
    out_word_t w;
    longint dxx, dyy, dxy, s, l1, l2, score, num, dir, hp, adxy, anum;
    logic [67:0] disc, cand, root;
    logic [33:0] diff_abs, twice_xy;
    dxx = h.dxx; dyy = h.dyy; dxy = h.dxy;
    diff_abs = 34'((dxx - dyy) < 0 ? dyy - dxx : dxx - dyy);
    twice_xy = 34'(dxy < 0 ? -2 * dxy : 2 * dxy);
    disc = 68'(diff_abs) * 68'(diff_abs) + 68'(twice_xy) * 68'(twice_xy);
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (68'd1 << b);
      if (cand * cand <= disc) root = cand;
    end
    s = dxx + dyy;
    l1 = floor_shr(s + longint'(root), 1);
    l2 = floor_shr(s - longint'(root), 1);
    score = -l2 - (l1 < 0 ? -l1 : l1);
    if (score < 0) score = 0;
    num = l1 - dxx;
    hp = floor_shr(HALF_PI_Q32 + (64'sd1 <<< (31 - FB)), 32 - FB);
    dir = 0;
    w.direction_undefined = 1'b0;
    if (dxy == 0) begin
      if (num > 0) dir = hp;
      else if (num < 0) dir = -hp;
      else w.direction_undefined = 1'b1;
    end else if (num != 0) begin
      adxy = dxy < 0 ? -dxy : dxy;
      anum = num < 0 ? -num : num;
      dir = vector_angle(adxy, anum);
      if ((num < 0) != (dxy < 0)) dir = -dir;
    end
    w.eig_major = MAJ_W'(clamp(l1, -(64'sd1 <<< 25), (64'sd1 <<< 25) - 1));
    w.eig_minor = MAJ_W'(clamp(l2, -(64'sd1 <<< 25), (64'sd1 <<< 25) - 1));
    w.ridge_score = SCORE_W'(clamp(score, 0, (64'sd1 <<< 25) - 1));
    w.direction = DIR_W'(clamp(dir, -(64'sd1 <<< 21), (64'sd1 <<< 21) - 1));
    return w;
  endfunction

  // Random field, biased toward extremes and small values
  function automatic logic signed [IW-1:0] rand_deriv();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(IW-1){1'b1}}};
      1: return {1'b1, {(IW-1){1'b0}}};
      2: return '0;
      3, 4: return IW'($signed($urandom_range(0, 64)) - 32);
      default: return IW'($urandom);
    endcase
  endfunction

  // Driver: present a word, hold until accepted, then wait a random gap
  always @(negedge clk) begin
    bit taken;
    taken = in_taken;
    in_taken = 1'b0;
    if (!rst) begin
      if (taken) begin
        send_gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      end
      if (in_valid && !taken) begin
        // hold payload
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_sender) begin
        in_valid <= 1'b1;
        deriv_xx <= pending_words[0].dxx;
        deriv_yy <= pending_words[0].dyy;
        deriv_xy <= pending_words[0].dxy;
      end else begin
        in_valid <= 1'b0;
      end
      // receiver stall, drawn once per accepted word
      if (out_taken) begin
        out_taken = 1'b0;
        recv_gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on accepted inputs, check accepted outputs
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_words.insert(expected_words.size(), ridge_of(pending_words[0]));
        void'(pending_words.pop_front());
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, actual %p", $time,
                   out_word_t'({eig_major, eig_minor, ridge_score, direction,
                                direction_undefined}));
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (eig_major !== exp_w.eig_major) begin
            $display("%0t: eig_major expected %0d actual %0d", $time,
                     exp_w.eig_major, eig_major);
            errors++;
          end
          if (eig_minor !== exp_w.eig_minor) begin
            $display("%0t: eig_minor expected %0d actual %0d", $time,
                     exp_w.eig_minor, eig_minor);
            errors++;
          end
          if (ridge_score !== exp_w.ridge_score) begin
            $display("%0t: ridge_score expected %0d actual %0d", $time,
                     exp_w.ridge_score, ridge_score);
            errors++;
          end
          if (direction !== exp_w.direction) begin
            $display("%0t: direction expected %0d actual %0d", $time,
                     exp_w.direction, direction);
            errors++;
          end
          if (direction_undefined !== exp_w.direction_undefined) begin
            $display("%0t: direction_undefined expected %0b actual %0b", $time,
                     exp_w.direction_undefined, direction_undefined);
            errors++;
          end
        end
      end
      // watchdog on cycles with no transfer
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else if (!stim_done || expected_words.size() > 0) stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_hessian_ridge_score_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    logic signed [IW-1:0] mx, mn;
    mx = {1'b0, {(IW-1){1'b1}}};
    mn = {1'b1, {(IW-1){1'b0}}};
    // directed: extremes and the zero-dxy cases
    queue_word(mx, mx, mx);
    queue_word(mn, mn, mn);
    queue_word(mx, mn, mn);
    queue_word(mn, mx, mx);
    queue_word(mn, mx, mn);
    queue_word(mx, mn, mx);
    queue_word(0, 0, 0);
    queue_word(100, 5, 0);
    queue_word(5, 100, 0);
    queue_word(7, 7, 0);
    queue_word(mn, 0, 0);
    queue_word(0, 0, 1);
    queue_word(0, 0, -1);
    queue_word(-1048576, -3145728, 0);
    queue_word(-3145728, 1048576, 524288);
    queue_word(1, -1, 1);
    queue_word(-5, -5, 3);
    queue_word(3, 3, mx);
    queue_word(mx, 0, 1);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      queue_word(rand_deriv(), rand_deriv(), rand_deriv());
      // hold the sender until the pipeline has drained
      if (i == N_RANDOM / 2) begin
        wait (pending_words.size() == 0);
        hold_sender = 1'b1;
        wait (expected_words.size() == 0);
        hold_sender = 1'b0;
      end
    end
    wait (pending_words.size() == 0 && !in_valid);
    stim_done = 1'b1;
    wait (expected_words.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_hessian_ridge_score_top: done, clean");
    end else begin
      $display("tb_hessian_ridge_score_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hrs_pkg.sv
hw/rtl/hrs_front.sv
hw/rtl/hrs_isqrt.sv
hw/rtl/hrs_eigen.sv
hw/rtl/hrs_cordic.sv
hw/rtl/hrs_out_buf.sv
hw/rtl/hessian_ridge_score_top.sv
test/tb_hessian_ridge_score_top.sv
